### rtl/core/gks_pkg.sv
// ----------------------------------------------------------------------------
// gks_pkg
// Shared types and request codes of the grid kernel scatter block.
// ----------------------------------------------------------------------------
package gks_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR   = 3'd0,
    REQ_WEIGHT  = 3'd1,
    REQ_DEPOSIT = 3'd2,
    REQ_FOLD    = 3'd3,
    REQ_READ    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLS    = 2'd1,
    CFG_RADIUS  = 2'd2,
    CFG_REFLECT = 2'd3
  } cfg_e;

  localparam int unsigned CellW = 48;
  localparam logic [CellW-1:0] CellMax = {CellW{1'b1}};

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_FOLD_RD,
    ST_FOLD_WR,
    ST_ZERO,
    ST_READ_RD,
    ST_READ_OUT
  } state_e;

endpackage

### rtl/core/gks_front.sv
// ----------------------------------------------------------------------------
// gks_front
// Input queue of two entries that decouples request intake from execution.
// ----------------------------------------------------------------------------
module gks_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  gks_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output gks_pkg::item_t item_o
);
  import gks_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

### rtl/core/gks_back.sv
// ----------------------------------------------------------------------------
// gks_back
// Sequencer that carries out requests on the padded grid memory.
// ----------------------------------------------------------------------------
module gks_back #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  gks_pkg::item_t            item_i,
  output logic                      take_o,
  input  logic [6:0]                rows_i,
  input  logic [6:0]                cols_i,
  input  logic [2:0]                radius_i,
  input  logic                      reflect_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [gks_pkg::CellW-1:0] cell_value_o
);
  import gks_pkg::*;

  localparam int unsigned PadR  = MAX_ROWS + 2 * MAX_RADIUS;
  localparam int unsigned PadC  = MAX_COLS + 2 * MAX_RADIUS;
  localparam int unsigned Depth = PadR * PadC;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(PadR + 1);
  localparam int unsigned CW    = $clog2(PadC + 1);
  localparam int unsigned KSide = 2 * MAX_RADIUS + 1;
  localparam int unsigned KN    = KSide * KSide;
  localparam int unsigned KW    = $clog2(KSide + 1);
  localparam int unsigned KAW   = (KN > 1) ? $clog2(KN) : 1;
  localparam int unsigned DW    = $clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1) ?
                                  $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
  localparam int unsigned EW    = DW > 5 ? DW : 5;

  logic [CellW-1:0] grid_q [Depth];
  logic [15:0]      kern_q [KN];
  logic [KN-1:0]    kval_q;

  state_e           state_q, state_d;
  item_t            cur_q;
  logic [RW-1:0]    i_q, i_d;
  logic [CW-1:0]    j_q, j_d;
  logic [KW-1:0]    kr_q, kr_d, kc_q, kc_d;
  logic [4:0]       ring_q, ring_d;
  logic [1:0]       side_q, side_d;
  logic [CellW-1:0] rd_q, add_q;
  logic [15:0]      kw_q;
  logic             out_v_q;
  logic [CellW-1:0] out_q;

  logic [EW-1:0] rows, cols, rad;
  always_comb begin
    rows = EW'(rows_i);
    if (rows == '0) rows = EW'(1);
    if (rows > EW'(MAX_ROWS)) rows = EW'(MAX_ROWS);
    cols = EW'(cols_i);
    if (cols == '0) cols = EW'(1);
    if (cols > EW'(MAX_COLS)) cols = EW'(MAX_COLS);
    rad = EW'(radius_i);
    if (rad > EW'(MAX_RADIUS)) rad = EW'(MAX_RADIUS);
  end

  logic [EW:0] off, prows, pcols, src, dst, len;
  assign off   = (EW+1)'(MAX_RADIUS) - {1'b0, rad};
  assign prows = {1'b0, rows} + {rad, 1'b0};
  assign pcols = {1'b0, cols} + {rad, 1'b0};
  always_comb begin
    case (side_q)
      2'd0: begin dst = {rad, 1'b0} - 1'b1 - ring_q; src = (EW+1)'(ring_q); len = pcols; end
      2'd1: begin dst = {rad, 1'b0} - 1'b1 - ring_q; src = (EW+1)'(ring_q); len = prows; end
      2'd2: begin dst = {1'b0, rows} + ring_q; src = prows - 1'b1 - ring_q; len = pcols; end
      default: begin
        dst = {1'b0, cols} + ring_q; src = pcols - 1'b1 - ring_q; len = prows;
      end
    endcase
  end

  // Address of the current step, and the fold source, per state.
  logic [RW+1:0] ar, sr_;
  logic [CW+1:0] ac, sc_;
  logic [AW+1:0] addr, saddr;
  logic          inb;
  always_comb begin
    ar = '0; ac = '0;
    sr_ = '0; sc_ = '0;
    case (state_q)
      ST_DEP_RD, ST_DEP_WR: begin
        ar = (RW+2)'(cur_q.row) + (RW+2)'(off) + (RW+2)'(kr_q);
        ac = (CW+2)'(cur_q.col) + (CW+2)'(off) + (CW+2)'(kc_q);
      end
      ST_FOLD_RD, ST_FOLD_WR: begin
        if (side_q[0]) begin
          ar = (RW+2)'(i_q) + (RW+2)'(off); ac = (CW+2)'(dst + off);
          sr_ = ar; sc_ = (CW+2)'(src + off);
        end else begin
          ar = (RW+2)'(dst + off); ac = (CW+2)'(i_q) + (CW+2)'(off);
          sr_ = (RW+2)'(src + off); sc_ = ac;
        end
      end
      ST_READ_RD: begin
        ar = (RW+2)'(cur_q.row) + (RW+2)'(MAX_RADIUS);
        ac = (CW+2)'(cur_q.col) + (CW+2)'(MAX_RADIUS);
      end
      default: begin
        ar = (RW+2)'(i_q); ac = (CW+2)'(j_q);
      end
    endcase
    addr  = (AW+2)'(ar * PadC + ac);
    saddr = (AW+2)'(sr_ * PadC + sc_);
    inb   = ar < PadR && ac < PadC;
  end

  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  assign wa = addr[AW-1:0];
  assign ra = (state_q == ST_FOLD_RD) ? saddr[AW-1:0] : addr[AW-1:0];

  logic [KAW-1:0] kaddr;
  assign kaddr = KAW'(kr_q * KSide + kc_q);

  logic [31:0]      prod;
  logic [CellW-1:0] addend;
  logic [CellW:0]   sum;
  logic [CellW-1:0] sat;
  assign prod   = {16'd0, cur_q.value} * {16'd0, kw_q};
  assign addend = (state_q == ST_DEP_WR) ? CellW'(prod) : add_q;
  assign sum    = {1'b0, rd_q} + {1'b0, addend};
  assign sat    = sum[CellW] ? CellMax : sum[CellW-1:0];

  logic last_k, last_i, last_z, last_ring;
  assign last_k    = kc_q == KW'({rad, 1'b0}) && kr_q == KW'({rad, 1'b0});
  assign last_i    = (EW+1)'(i_q) == len - 1'b1;
  assign last_z    = i_q == RW'(PadR - 1) && j_q == CW'(PadC - 1);
  assign last_ring = side_q == 2'd3 && EW'(ring_q) + 1'b1 == rad;

  logic is_border;
  assign is_border = i_q < RW'(MAX_RADIUS) || i_q >= RW'(MAX_RADIUS) + RW'(rows)
                  || j_q < CW'(MAX_RADIUS) || j_q >= CW'(MAX_RADIUS) + CW'(cols);

  logic             grid_we;
  logic [CellW-1:0] grid_wd;
  always_comb begin
    grid_we = 1'b0;
    grid_wd = '0;
    if ((state_q == ST_DEP_WR || state_q == ST_FOLD_WR) && inb) begin
      grid_we = 1'b1;
      grid_wd = sat;
    end else if (state_q == ST_CLEAR || (state_q == ST_ZERO && is_border)) begin
      grid_we = 1'b1;
    end
  end

  assign take_o  = state_q == ST_IDLE && valid_i;
  assign empty_o = !out_v_q;
  assign cell_value_o = out_q;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; kr_d = kr_q; kc_d = kc_q;
    ring_d = ring_q; side_d = side_q;
    case (state_q)
      ST_IDLE: begin
        i_d = '0; j_d = '0; kr_d = '0; kc_d = '0; ring_d = '0; side_d = '0;
        if (take_o) begin
          case (item_i.req_type)
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_DEPOSIT:
              if (EW'(item_i.row) < rows && EW'(item_i.col) < cols) state_d = ST_DEP_RD;
            REQ_FOLD: state_d = (reflect_i && rad != '0) ? ST_FOLD_RD : ST_ZERO;
            REQ_READ: state_d = ST_READ_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DEP_RD: state_d = ST_DEP_WR;
      ST_DEP_WR: begin
        state_d = ST_DEP_RD;
        if (kc_q == KW'({rad, 1'b0})) begin
          kc_d = '0; kr_d = kr_q + 1'b1;
        end else kc_d = kc_q + 1'b1;
        if (last_k) state_d = ST_IDLE;
      end
      ST_FOLD_RD: state_d = ST_FOLD_WR;
      ST_FOLD_WR: begin
        state_d = ST_FOLD_RD;
        i_d = i_q + 1'b1;
        if (last_i) begin
          i_d = '0;
          side_d = side_q + 1'b1;
          if (side_q == 2'd3) ring_d = ring_q + 1'b1;
          if (last_ring) begin
            state_d = ST_ZERO;
            j_d = '0;
          end
        end
      end
      ST_CLEAR, ST_ZERO: begin
        if (j_q == CW'(PadC - 1)) begin
          j_d = '0; i_d = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
        if (last_z) state_d = ST_IDLE;
      end
      ST_READ_RD: state_d = ST_READ_OUT;
      ST_READ_OUT: if (!out_v_q || pop_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && take_o) cur_q <= item_i;
    if (state_q == ST_DEP_RD || state_q == ST_FOLD_RD || state_q == ST_READ_RD)
      rd_q <= grid_q[ra];
    if (state_q == ST_DEP_RD) kw_q <= kval_q[kaddr] ? kern_q[kaddr] : 16'd0;
    if (state_q == ST_FOLD_RD) add_q <= inb ? grid_q[wa] : '0;
    if (grid_we) grid_q[wa] <= grid_wd;
    if (state_q == ST_IDLE && take_o && item_i.req_type == REQ_WEIGHT &&
        item_i.row < 6'(KSide) && item_i.col < 6'(KSide))
      kern_q[KAW'(item_i.row * KSide + item_i.col)] <= item_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      i_q <= '0; j_q <= '0; kr_q <= '0; kc_q <= '0;
      ring_q <= '0; side_q <= '0;
      kval_q <= '0;
      out_v_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; kr_q <= kr_d; kc_q <= kc_d;
      ring_q <= ring_d; side_q <= side_d;
      if (state_q == ST_IDLE && take_o && item_i.req_type == REQ_WEIGHT &&
          item_i.row < 6'(KSide) && item_i.col < 6'(KSide))
        kval_q[KAW'(item_i.row * KSide + item_i.col)] <= 1'b1;
      if (state_q == ST_READ_OUT && (!out_v_q || pop_i)) begin
        out_v_q <= 1'b1;
        out_q <= (EW'(cur_q.row) < rows && EW'(cur_q.col) < cols) ? rd_q : '0;
      end else if (pop_i && out_v_q) begin
        out_v_q <= 1'b0;
      end
    end
  end
endmodule

### rtl/core/grid_kernel_scatter_with_reflection.sv
// A read result is registered via ST_READ_RD and ST_READ_OUT; a deposit reads and
// writes each of (2r+1)^2 cells. A fold, if reflecting, reads and writes each cell
// of 4r passes, then sweeps the padded store one cell per cycle (5184 by default),
// zeroing its border; a clear is the same sweep, zeroing every cell. One request at
// a time is executed; the input queue holds two. Reset empties both queues,
// restores register defaults and starts one clearing sweep.
// ----------------------------------------------------------------------------
// grid_kernel_scatter_with_reflection
// Top level: configuration registers, input queue and execution sequencer.
// ----------------------------------------------------------------------------
module grid_kernel_scatter_with_reflection #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [15:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [47:0] cell_value_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);
  import gks_pkg::*;

  logic [6:0] rows_q, cols_q;
  logic [2:0] rad_q;
  logic       refl_q;
  item_t      in_item, q_item;
  logic       q_valid, q_take;

  assign in_item = '{req_type: req_type_i, row: row_i, col: col_i, value: value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd64; cols_q <= 7'd64; rad_q <= 3'd1; refl_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_RADIUS: rad_q  <= cfg_data_i[2:0];
        default: refl_q <= cfg_data_i[0];
      endcase
    end
  end

  gks_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  gks_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .take_o(q_take),
    .rows_i(rows_q), .cols_i(cols_q), .radius_i(rad_q), .reflect_i(refl_q),
    .empty_o(empty), .pop_i(pop), .cell_value_o(cell_value_o)
  );
endmodule

### rtl/core/gks_checker.sv
// ----------------------------------------------------------------------------
// gks_checker
// Port-level checks of the scatter block.
// ----------------------------------------------------------------------------
module gks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [47:0] cell_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(cell_value_o)) else $error("result changed");
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty || !rst_ni)
    else $error("result after reset");
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push)) else $error("full without push");
endmodule

bind grid_kernel_scatter_with_reflection gks_checker u_gks_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .cell_value_o
);
